### rtl/voltage_running_statistics_macros.svh
// Assertion helpers for the RTL file that asserts.
`ifndef VOLTAGE_RUNNING_STATISTICS_MACROS_SVH
`define VOLTAGE_RUNNING_STATISTICS_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define VRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define VRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/vrs_pkg.sv
`default_nettype none
package vrs_pkg;

  localparam int COUNT_BITS   = 22;
  localparam int SUM_BITS     = 32;
  localparam int CODE_BITS    = 10;
  localparam int MV_BITS      = 16;
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS);

  // floor(x / 1023) == (x * MV_RECIP) >> MV_SHIFT for x < 2^26
  localparam int MUL_BITS = 27;
  localparam int PROD_BITS = 2 * MUL_BITS;
  localparam int SCALED_BITS = CODE_BITS + MV_BITS;
  localparam int MV_SHIFT = 36;
  localparam logic [MUL_BITS-1:0] MV_RECIP = 27'd67174465;

  localparam logic [MV_BITS-1:0] FULLSCALE_RESET = 16'd5000;

  localparam logic [3:0] KEY_STOP  = 4'd1;
  localparam logic [3:0] KEY_START = 4'd2;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_IDLE    = 2'd1,
    MODE_MEASURE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_READY,
    S_DIV_GO,
    S_DIV,
    S_MUL_A,
    S_MUL_B,
    S_MUL_C,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [3:0]           key_code;
    logic [CODE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [MV_BITS-1:0] current_mv;
    logic [MV_BITS-1:0] average_mv;
    logic [MV_BITS-1:0] max_mv;
    logic [MV_BITS-1:0] min_mv;
  } out_item_t;

endpackage
`default_nettype wire

### rtl/vrs_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module vrs_divider import vrs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [SUM_BITS-1:0]   dividend,
  input  wire logic [COUNT_BITS-1:0] divisor,
  output logic                       done,
  output logic [SUM_BITS-1:0]        quotient
);

  logic [SUM_BITS-1:0]     dvd;
  logic [COUNT_BITS-1:0]   rem;
  logic [COUNT_BITS-1:0]   dsr;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    busy;
  logic [COUNT_BITS:0]     rem_shift;
  logic                    fits;

  assign rem_shift = {rem, dvd[SUM_BITS-1]};
  assign fits      = rem_shift >= {1'b0, dsr};
  assign quotient  = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_BITS'(SUM_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[SUM_BITS-2:0], fits};
      if (fits) begin
        rem <= COUNT_BITS'(rem_shift - {1'b0, dsr});
      end else begin
        rem <= rem_shift[COUNT_BITS-1:0];
      end
    end
  end

endmodule
`default_nettype wire

### rtl/voltage_running_statistics.sv
`default_nettype none
// Voltmeter statistics engine: running min, max and mean of 10-bit ADC codes.
// Input channel (in_valid/in_stall/in_data): one beat per tick, carrying a
// key code and a sample. A beat is taken when in_valid is high and in_stall
// low; in_stall is high for the whole time an item is being worked on.
// Output channel (out_valid/out_stall/out_data): exactly one result beat per
// input beat, in order: mode plus current, average, max and min millivolts.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes fullscale_mv, always
// ready; write it only while the block is idle.
// Sequence: a tick that takes a sample below the count limit passes through
// accept, divider launch, the divider steps, the four millivolt conversions
// and the output load; a measuring tick without a new mean skips the divider;
// a non-measuring tick goes from accept straight to the output load. The
// 32-step serial divider for the mean and the shared multiplier set its pace.
// Reset (rst, synchronous): start mode, all statistics zero, fullscale 5000.
// A stalled receiver holds the result in the output register; the next
// item may already be accepted and waits in S_OUT until the register frees.
module voltage_running_statistics import vrs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_item_t               out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [MV_BITS-1:0] cfg_data
);

  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

  state_t state, state_next;
  mode_t  mode_reg, mode_next;

  logic [MV_BITS-1:0]    fullscale_mv;
  logic [CODE_BITS-1:0]  latest_code, latest_code_next;
  logic [CODE_BITS-1:0]  min_code, min_code_next;
  logic [CODE_BITS-1:0]  max_code, max_code_next;
  logic [CODE_BITS-1:0]  mean_code;
  logic [SUM_BITS-1:0]   sample_sum, sample_sum_next;
  logic [COUNT_BITS-1:0] sample_count, sample_count_next;
  logic                  need_div;

  logic [SUM_BITS:0]     sum_wide;
  logic                  in_accept;
  logic                  out_load;

  // millivolt conversion sequencing
  logic [1:0]            idx;
  logic [MV_BITS-1:0]    mv [4];
  logic [CODE_BITS-1:0]  code_sel;
  logic [MUL_BITS-1:0]   mul_a, mul_b;
  logic [PROD_BITS-1:0]  product;

  logic                  div_start;
  logic                  div_done;
  logic [SUM_BITS-1:0]   div_quotient;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_READY);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == S_OUT) && (!out_valid || !out_stall);
  assign div_start = (state == S_DIV_GO);

  vrs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sample_sum),
    .divisor  (sample_count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Mode step and statistics update for one tick.
  always_comb begin
    mode_next         = mode_reg;
    latest_code_next  = latest_code;
    min_code_next     = min_code;
    max_code_next     = max_code;
    sample_sum_next   = sample_sum;
    sample_count_next = sample_count;
    need_div          = 1'b0;
    sum_wide          = {1'b0, sample_sum} + (SUM_BITS + 1)'(in_data.sample);
    unique case (mode_reg)
      MODE_IDLE: begin
        if (in_data.key_code == KEY_START) begin
          mode_next = MODE_MEASURE;
        end else begin
          latest_code_next  = '0;
          min_code_next     = '0;
          max_code_next     = '0;
          sample_sum_next   = '0;
          sample_count_next = '0;
        end
      end
      MODE_MEASURE: begin
        if (in_data.key_code == KEY_STOP) begin
          mode_next = MODE_IDLE;
        end else begin
          latest_code_next = in_data.sample;
          if (sample_count == '0) begin
            // first sample seeds both extremes
            min_code_next = in_data.sample;
            max_code_next = in_data.sample;
          end else begin
            if (in_data.sample < min_code) min_code_next = in_data.sample;
            if (in_data.sample > max_code) max_code_next = in_data.sample;
          end
          if (sample_count != COUNT_LIMIT) begin
            sample_sum_next   = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
            sample_count_next = sample_count + 1'b1;
            need_div          = 1'b1;
          end
        end
      end
      default: begin
        // start, and the unreachable fourth code, go to idle
        mode_next = MODE_IDLE;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_READY: begin
        if (in_accept) begin
          if (mode_next != MODE_MEASURE) begin
            state_next = S_OUT;
          end else if (need_div) begin
            state_next = S_DIV_GO;
          end else begin
            state_next = S_MUL_A;
          end
        end
      end
      S_DIV_GO: state_next = S_DIV;
      S_DIV:    if (div_done) state_next = S_MUL_A;
      S_MUL_A:  state_next = S_MUL_B;
      S_MUL_B:  state_next = S_MUL_C;
      S_MUL_C:  state_next = (idx == 2'd3) ? S_OUT : S_MUL_A;
      S_OUT:    if (out_load) state_next = S_READY;
      default:  state_next = S_READY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_READY;
    end else begin
      state <= state_next;
    end
  end

  // Configuration and statistics registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fullscale_mv <= FULLSCALE_RESET;
      mode_reg     <= MODE_START;
      latest_code  <= '0;
      min_code     <= '0;
      max_code     <= '0;
      mean_code    <= '0;
      sample_sum   <= '0;
      sample_count <= '0;
    end else begin
      if (cfg_valid && cfg_ready) fullscale_mv <= cfg_data;
      if (in_accept) begin
        mode_reg     <= mode_next;
        latest_code  <= latest_code_next;
        min_code     <= min_code_next;
        max_code     <= max_code_next;
        sample_sum   <= sample_sum_next;
        sample_count <= sample_count_next;
        if (mode_reg == MODE_IDLE && mode_next == MODE_IDLE) mean_code <= '0;
      end
      if (state == S_DIV && div_done) mean_code <= div_quotient[CODE_BITS-1:0];
    end
  end

  // Shared multiplier: code * fullscale, then * reciprocal of 1023.
  always_comb begin
    unique case (idx)
      2'd0: code_sel = latest_code;
      2'd1: code_sel = mean_code;
      2'd2: code_sel = max_code;
      2'd3: code_sel = min_code;
      default: code_sel = latest_code;
    endcase
    if (state == S_MUL_B) begin
      mul_a = MUL_BITS'(product[SCALED_BITS-1:0]);
      mul_b = MV_RECIP;
    end else begin
      mul_a = MUL_BITS'(code_sel);
      mul_b = MUL_BITS'(fullscale_mv);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (in_accept) begin
      idx <= '0;
    end else if (state == S_MUL_C) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL_A || state == S_MUL_B) product <= mul_a * mul_b;
    if (state == S_MUL_C) mv[idx] <= product[MV_SHIFT +: MV_BITS];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.mode <= mode_reg;
      if (mode_reg == MODE_MEASURE) begin
        out_data.current_mv <= mv[0];
        out_data.average_mv <= mv[1];
        out_data.max_mv     <= mv[2];
        out_data.min_mv     <= mv[3];
      end else begin
        // dashes on the display
        out_data.current_mv <= '0;
        out_data.average_mv <= '0;
        out_data.max_mv     <= '0;
        out_data.min_mv     <= '0;
      end
    end
  end

`include "voltage_running_statistics_macros.svh"

  `VRS_ASSERT_NEXT(a_busy_after_accept, in_accept, state != S_READY, "accept left block ready")
  `VRS_ASSERT_NOW(a_div_done_in_div, div_done, state == S_DIV, "divider done outside wait")
  `VRS_ASSERT_NOW(a_dashes_zero, out_valid && out_data.mode != MODE_MEASURE,
    out_data.current_mv == '0 && out_data.average_mv == '0 && out_data.max_mv == '0 &&
    out_data.min_mv == '0, "nonzero values outside measure")
  `VRS_ASSERT_NOW(a_max_ge_min, out_valid && out_data.mode == MODE_MEASURE,
    out_data.max_mv >= out_data.min_mv, "max below min")

endmodule
`default_nettype wire

### dv/tb_top.sv
`default_nettype none
module tb_top;
  import vrs_pkg::*;

  // Keypad codes not named in the package. Keys 3..12 are plain keys.
  localparam logic [3:0] KEY_NONE = 4'd0;
  localparam logic [3:0] KEY_PLAIN_LO = 4'd3;
  localparam logic [3:0] KEY_LAST = 4'd12;
  localparam logic [CODE_BITS-1:0] CODE_FULL = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;
  localparam logic [SUM_BITS-1:0] SUM_FULL = '1;

  // Sender gaps and receiver stalls lengthen each tick; the limit bounds the whole run.
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_TICKS = 600;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MV_BITS-1:0] cfg_data = '0;

  voltage_running_statistics uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Meter model: mode, held statistics and the scale register.
  // Updated once per accepted input beat, in acceptance order.
  // ---------------------------------------------------------------------
  mode_t                meter_mode;
  logic [CODE_BITS-1:0] last_code;
  logic [CODE_BITS-1:0] lo_code;
  logic [CODE_BITS-1:0] hi_code;
  logic [CODE_BITS-1:0] mean_code;
  logic [SUM_BITS-1:0]  code_sum;
  logic [COUNT_BITS-1:0] code_count;
  logic [MV_BITS-1:0]   scale_mv;

  // Expected result beats, oldest first.
  out_item_t expected_q[$];

  int mismatches = 0;
  int cycle_count = 0;
  int ticks_sent = 0;

  // Sender burst shaping: beats left in this burst, and the widest gap.
  int burst_left = 0;
  int gap_max = 0;

  // Receiver stall pattern: duty in percent, held for a random stretch.
  int stall_pct = 0;
  int stall_left = 0;

  function automatic void clear_meter();
    last_code = '0;
    lo_code = '0;
    hi_code = '0;
    mean_code = '0;
    code_sum = '0;
    code_count = '0;
  endfunction

  // floor(code * scale / 1023), kept to the 16-bit result width
  function automatic logic [MV_BITS-1:0] code_to_mv(logic [CODE_BITS-1:0] code);
    logic [63:0] prod;
    prod = 64'(code) * 64'(scale_mv);
    return MV_BITS'(prod / 64'(CODE_FULL));
  endfunction

  function automatic void absorb_code(logic [CODE_BITS-1:0] code);
    logic [SUM_BITS:0] wide_sum;
    last_code = code;
    // first sample after a clear seeds both extremes
    if (code_count == '0) begin
      lo_code = code;
      hi_code = code;
    end else begin
      if (code < lo_code) lo_code = code;
      if (code > hi_code) hi_code = code;
    end
    // count full: sum, count and mean all hold
    if (code_count != COUNT_FULL) begin
      wide_sum = {1'b0, code_sum} + (SUM_BITS+1)'(code);
      code_sum = wide_sum[SUM_BITS] ? SUM_FULL : wide_sum[SUM_BITS-1:0];
      code_count = code_count + 1'b1;
      mean_code = CODE_BITS'(code_sum / SUM_BITS'(code_count));
    end
  endfunction

  function automatic out_item_t predict_tick(in_item_t beat);
    out_item_t res;
    case (meter_mode)
      MODE_IDLE: begin
        if (beat.key_code == KEY_START) meter_mode = MODE_MEASURE;
        else clear_meter();
      end
      MODE_MEASURE: begin
        if (beat.key_code == KEY_STOP) meter_mode = MODE_IDLE;
        else absorb_code(beat.sample);
      end
      default: begin
        meter_mode = MODE_IDLE;
      end
    endcase
    res = '0;
    res.mode = meter_mode;
    // outside measure the display shows dashes: all values zero
    if (meter_mode == MODE_MEASURE) begin
      res.current_mv = code_to_mv(last_code);
      res.average_mv = code_to_mv(mean_code);
      res.max_mv = code_to_mv(hi_code);
      res.min_mv = code_to_mv(lo_code);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: every accepted output beat against the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------
  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("MISMATCH %s: expected %0d, got %0d (tick %0d pending)",
               what, want, got, expected_q.size());
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        note_mismatch("unexpected result beat", 0, 1);
      end else begin
        want = expected_q.pop_front();
        if (out_data.mode != want.mode)
          note_mismatch("mode", want.mode, out_data.mode);
        if (out_data.current_mv != want.current_mv)
          note_mismatch("current_mv", want.current_mv, out_data.current_mv);
        if (out_data.average_mv != want.average_mv)
          note_mismatch("average_mv", want.average_mv, out_data.average_mv);
        if (out_data.max_mv != want.max_mv)
          note_mismatch("max_mv", want.max_mv, out_data.max_mv);
        if (out_data.min_mv != want.min_mv)
          note_mismatch("min_mv", want.min_mv, out_data.min_mv);
      end
    end
  end

  // Receiver stalls: random duty held for a random stretch. A zero duty
  // gives stretches with no back-pressure at all.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(3, 0))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 50;
        default: stall_pct = 80;
      endcase
      stall_left = $urandom_range(300, 20);
    end
    stall_left--;
    out_stall <= ($urandom_range(99, 0) < stall_pct);
  end

  // Run-away guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d beats outstanding",
               cycle_count, expected_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // One input beat. Valid stays high across a burst; between bursts it
  // drops for a random gap.
  task automatic send_tick(input logic [3:0] key, input logic [CODE_BITS-1:0] code);
    in_item_t beat;
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(16, 1);
    end
    burst_left--;
    beat.key_code = key;
    beat.sample = code;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_tick(beat));
    ticks_sent++;
  endtask

  // Stop sending and hold off until every result beat has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Scale register write; only called with the meter drained.
  task automatic write_scale(input logic [MV_BITS-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    scale_mv = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CODE_BITS-1:0] pick_code();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return CODE_FULL;
      default: return CODE_BITS'($urandom_range(int'(CODE_FULL), 0));
    endcase
  endfunction

  // Keys that take a sample in measure: none, start or a plain key.
  function automatic logic [3:0] pick_sample_key();
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4, 5: return KEY_NONE;
      6: return KEY_START;
      default: return 4'($urandom_range(int'(KEY_LAST), int'(KEY_PLAIN_LO)));
    endcase
  endfunction

  // Any key but start; in idle this clears the statistics.
  function automatic logic [3:0] pick_clear_key();
    logic [3:0] k;
    k = 4'($urandom_range(int'(KEY_LAST), 0));
    return (k == KEY_START) ? KEY_NONE : k;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Mode walk at the reset scale: start, clear, enter measure with zeros,
  // first-sample seeding, code extremes, stop, resume on held stats.
  task automatic test_mode_walk();
    send_tick(4'd5, 10'd77);          // start always goes to idle
    send_tick(KEY_NONE, 10'd900);     // idle, no key: clears
    send_tick(KEY_START, 10'd1000);   // enter measure, no sample taken
    send_tick(KEY_NONE, CODE_FULL);   // first sample seeds min and max
    send_tick(KEY_NONE, 10'd0);
    send_tick(4'd3, 10'd341);
    send_tick(KEY_LAST, 10'd682);
    send_tick(KEY_START, 10'd512);    // start key in measure still samples
    send_tick(4'd8, 10'd1);
    send_tick(KEY_STOP, 10'd999);     // back to idle, dashes
    send_tick(KEY_START, 10'd3);      // resume: held stats shown
    send_tick(KEY_NONE, 10'd200);
    send_tick(KEY_STOP, 10'd4);
    send_tick(KEY_STOP, 10'd5);       // stop in idle clears too
    send_tick(KEY_START, 10'd6);      // zeros after the clear
    send_tick(KEY_NONE, 10'd700);
    send_tick(KEY_STOP, 10'd0);
    drain_results();
  endtask

  // Scale register at its extremes and at two middling values, with the code
  // extremes measured under each.
  task automatic test_scale_extremes();
    logic [MV_BITS-1:0] scales[4];
    scales = '{16'hFFFF, 16'd1, 16'd1023, 16'd3333};
    foreach (scales[i]) begin
      write_scale(scales[i]);
      send_tick(KEY_START, 10'd0);
      send_tick(KEY_NONE, CODE_FULL);
      send_tick(KEY_NONE, 10'd1);
      send_tick(KEY_NONE, 10'd0);
      send_tick(KEY_STOP, 10'd0);
      drain_results();
    end
  endtask

  // One measuring session: get to idle, maybe clear, enter measure, take
  // a run of samples, stop.
  task automatic measure_session();
    int n;
    if (meter_mode == MODE_MEASURE) send_tick(KEY_STOP, pick_code());
    else if (meter_mode != MODE_IDLE) send_tick(pick_clear_key(), pick_code());
    // sometimes keep the held stats to resume on them
    if ($urandom_range(3, 0) != 0) send_tick(pick_clear_key(), pick_code());
    send_tick(KEY_START, pick_code());
    n = ($urandom_range(7, 0) == 0) ? $urandom_range(120, 41) : $urandom_range(40, 1);
    repeat (n) send_tick(pick_sample_key(), pick_code());
    send_tick(KEY_STOP, pick_code());
  endtask

  // Random phases, each at its own scale and sender pacing. Mostly
  // well-formed sessions, with some raw noise beats mixed in.
  task automatic test_random_sessions();
    int start_count;
    int phase_end;
    start_count = ticks_sent;
    while (ticks_sent - start_count < RANDOM_TICKS) begin
      drain_results();
      case ($urandom_range(4, 0))
        0: write_scale(16'd1);
        1: write_scale(16'hFFFF);
        2: write_scale(FULLSCALE_RESET);
        default: write_scale(MV_BITS'($urandom_range(65535, 1)));
      endcase
      case ($urandom_range(2, 0))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 12;
      endcase
      phase_end = ticks_sent + $urandom_range(120, 40);
      while (ticks_sent < phase_end) begin
        if ($urandom_range(9, 0) == 0) begin
          repeat ($urandom_range(6, 1))
            send_tick(4'($urandom_range(int'(KEY_LAST), 0)), pick_code());
        end else begin
          measure_session();
        end
      end
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    meter_mode = MODE_START;
    clear_meter();
    scale_mv = FULLSCALE_RESET;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_mode_walk();
    test_scale_extremes();
    write_scale(FULLSCALE_RESET);
    test_random_sessions();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      mismatches++;
      $display("%0d result beats never arrived", expected_q.size());
    end
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
